FILE: hdl/track_average_speed_core_assert.svh
// ----------------------------------------------------------------------------
// Track average speed: assertion macros
// Shared property forms for the port-level checks of the speed core.
// ----------------------------------------------------------------------------
`ifndef TRACK_AVERAGE_SPEED_CORE_ASSERT_SVH
`define TRACK_AVERAGE_SPEED_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define TAS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("track speed check failed");

// next-cycle implication, disabled while reset is active
`define TAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("track speed check failed");

`endif

FILE: hdl/tas_pkg.sv
// ----------------------------------------------------------------------------
// Track average speed: package
// Widths and constants shared by the speed core and its iterative units.
// ----------------------------------------------------------------------------
package tas_pkg;

	localparam int POS_W      = 24;               // signed Q16.8 coordinate
	localparam int DIFF_W     = POS_W;            // magnitude of a coordinate step
	localparam int SQ_W       = 2 * DIFF_W;       // one square
	localparam int SSUM_W     = SQ_W + 1;         // sum of two squares
	localparam int ROOT_W     = (SSUM_W + 1) / 2; // floor root of the sum
	localparam int RAD_W      = 2 * ROOT_W;       // radicand padded to bit pairs
	localparam int REM_W      = ROOT_W + 3;       // root partial remainder
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

	localparam int DIST_W     = 48;               // path sum
	localparam int TIME_W     = 40;               // seconds sum
	localparam int FRAC_W     = 8;                // Q.8 to Q.16 scaling
	localparam int DIVD_W     = DIST_W + FRAC_W;  // dividend of the speed divide
	localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

	localparam int HOUR_W     = 8;
	localparam int MIN_W      = 6;
	localparam int SEC_W      = 6;
	localparam int TSEC_W     = 20;               // one interval in seconds

	localparam int SECS_PER_MIN  = 60;
	localparam int SECS_PER_HOUR = SECS_PER_MIN * SECS_PER_MIN;

	// stream word layouts
	localparam int IN_FIELDS_W  = 2 * POS_W + HOUR_W + MIN_W + SEC_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * DIST_W + TIME_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int X_LSB   = 0;
	localparam int Y_LSB   = X_LSB + POS_W;
	localparam int H_LSB   = Y_LSB + POS_W;
	localparam int MIN_LSB = H_LSB + HOUR_W;
	localparam int SEC_LSB = MIN_LSB + MIN_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

endpackage

FILE: hdl/tas_sqrt.sv
// ----------------------------------------------------------------------------
// Track average speed: square root unit
// Bit-pair restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tas_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tas_pkg::SSUM_W-1:0]    radicand,
	output logic                          done,
	output logic [tas_pkg::ROOT_W-1:0]    root
);

	logic                            busy_q;
	logic                            done_q;
	logic [tas_pkg::ROOT_CNT_W-1:0]  cnt_q;
	logic [tas_pkg::RAD_W-1:0]       rad_q;
	logic [tas_pkg::REM_W-1:0]       rem_q;
	logic [tas_pkg::ROOT_W-1:0]      root_q;

	logic [tas_pkg::REM_W-1:0]       rem_sh;
	logic [tas_pkg::REM_W-1:0]       trial;
	logic                            fits;

	assign rem_sh = {rem_q[tas_pkg::REM_W-3:0], rad_q[tas_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tas_pkg::ROOT_CNT_W'(tas_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tas_pkg::ROOT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= tas_pkg::RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[tas_pkg::RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[tas_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[tas_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/tas_div.sv
// ----------------------------------------------------------------------------
// Track average speed: divider unit
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tas_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tas_pkg::DIVD_W-1:0]    dividend,
	input  logic [tas_pkg::TIME_W-1:0]    divisor,
	output logic                          done,
	output logic [tas_pkg::DIVD_W-1:0]    quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [tas_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [tas_pkg::DIVD_W-1:0]      num_q;
	logic [tas_pkg::TIME_W-1:0]      den_q;
	logic [tas_pkg::TIME_W-1:0]      rem_q;

	logic [tas_pkg::TIME_W:0]        rem_sh;
	logic [tas_pkg::TIME_W:0]        diff;
	logic                            fits;

	// quotient bits shift in at the bottom as dividend bits leave the top
	assign rem_sh = {rem_q, num_q[tas_pkg::DIVD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tas_pkg::DIV_CNT_W'(tas_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tas_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[tas_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? diff[tas_pkg::TIME_W-1:0] : rem_sh[tas_pkg::TIME_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: hdl/track_average_speed_core.sv
// ----------------------------------------------------------------------------
// Track average speed core
// Sums point-to-point distances and intervals of a track, gives the average
// speed, path length and time on the record that closes the track.
// ----------------------------------------------------------------------------
// channel  dir  data                                       side band
// s_*      in   x_pos, y_pos, hours, minutes, seconds       tlast = last
// m_*      out  avg_speed, path_length, total_seconds       tuser = zero_time
//
// The first record of a track stores its point and goes straight to the end-of-track
// check. Later records pass through the shared multiplier (two squares) and the 25-step square root unit.
// The closing record also passes through the 56-step speed divider unless the summed time is zero.
// Reset clears the sums and the previous point; no clearing pass is needed.
// The result waits in the output register; a stalled result holds the next
// closing record in the sequencer until it is taken.
module track_average_speed_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// x_pos[23:0], y_pos[47:24], hours[55:48], minutes[61:56], seconds[67:62], zero fill
	input  logic [tas_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// avg_speed[47:0], path_length[95:48], total_seconds[135:96]
	output logic [tas_pkg::OUT_DATA_W-1:0]    m_tdata,
	// zero_time[0]
	output logic                              m_tuser
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SUM,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_ACC,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RESULT
	} state_t;

	state_t                               state_q;
	logic                                 m_valid_q;
	logic                                 have_prev_q;
	logic                                 last_q;
	logic signed [tas_pkg::POS_W-1:0]     prev_x_q;
	logic signed [tas_pkg::POS_W-1:0]     prev_y_q;
	logic [tas_pkg::DIST_W-1:0]           dist_q;
	logic [tas_pkg::TIME_W-1:0]           time_q;

	logic [tas_pkg::DIFF_W-1:0]           dx_q;
	logic [tas_pkg::DIFF_W-1:0]           dy_q;
	logic [tas_pkg::TSEC_W-1:0]           tsec_q;
	logic [tas_pkg::SQ_W-1:0]             sq_q;
	logic [tas_pkg::SSUM_W-1:0]           ssum_q;
	logic [tas_pkg::DIST_W-1:0]           avg_q;
	logic                                 zero_q;
	logic [tas_pkg::OUT_DATA_W-1:0]       m_data_q;
	logic                                 m_user_q;

	logic signed [tas_pkg::POS_W-1:0]     in_x;
	logic signed [tas_pkg::POS_W-1:0]     in_y;
	logic signed [tas_pkg::POS_W:0]       dxs;
	logic signed [tas_pkg::POS_W:0]       dys;
	logic [tas_pkg::POS_W:0]              dx_abs;
	logic [tas_pkg::POS_W:0]              dy_abs;
	logic [tas_pkg::TSEC_W-1:0]           in_tsec;
	logic                                 in_acc;
	logic [tas_pkg::DIFF_W-1:0]           mul_a;
	logic [tas_pkg::SQ_W-1:0]             prod;
	logic [tas_pkg::DIST_W:0]             dist_add;
	logic [tas_pkg::TIME_W:0]             time_add;
	logic                                 out_free;

	logic                                 root_done;
	logic [tas_pkg::ROOT_W-1:0]           root;
	logic                                 div_done;
	logic [tas_pkg::DIVD_W-1:0]           quot;

	assign in_x = s_tdata[tas_pkg::X_LSB +: tas_pkg::POS_W];
	assign in_y = s_tdata[tas_pkg::Y_LSB +: tas_pkg::POS_W];
	assign dxs  = {in_x[tas_pkg::POS_W-1], in_x} - {prev_x_q[tas_pkg::POS_W-1], prev_x_q};
	assign dys  = {in_y[tas_pkg::POS_W-1], in_y} - {prev_y_q[tas_pkg::POS_W-1], prev_y_q};
	assign dx_abs = dxs[tas_pkg::POS_W] ? (-dxs) : dxs;
	assign dy_abs = dys[tas_pkg::POS_W] ? (-dys) : dys;

	assign in_tsec =
		tas_pkg::TSEC_W'(s_tdata[tas_pkg::H_LSB +: tas_pkg::HOUR_W])
			* tas_pkg::TSEC_W'(tas_pkg::SECS_PER_HOUR)
		+ tas_pkg::TSEC_W'(s_tdata[tas_pkg::MIN_LSB +: tas_pkg::MIN_W])
			* tas_pkg::TSEC_W'(tas_pkg::SECS_PER_MIN)
		+ tas_pkg::TSEC_W'(s_tdata[tas_pkg::SEC_LSB +: tas_pkg::SEC_W]);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// one multiplier, squares dx then dy
	assign mul_a = (state_q == ST_MUL_X) ? dx_q : dy_q;
	assign prod  = mul_a * mul_a;

	assign dist_add = {1'b0, dist_q} + tas_pkg::DIST_W'(root);
	assign time_add = {1'b0, time_q} + tas_pkg::TIME_W'(tsec_q);
	assign out_free = !m_valid_q || m_tready;

	tas_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_ROOT_GO),
		.radicand (ssum_q),
		.done     (root_done),
		.root     (root)
	);

	tas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIV_GO),
		.dividend ({dist_q, tas_pkg::FRAC_W'(0)}),
		.divisor  (time_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_valid_q   <= 1'b0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			dist_q      <= '0;
			time_q      <= '0;
		end else begin
			if (m_tready && !((state_q == ST_RESULT) && out_free)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q      <= s_tlast;
						prev_x_q    <= in_x;
						prev_y_q    <= in_y;
						have_prev_q <= 1'b1;
						state_q     <= have_prev_q ? ST_MUL_X : ST_CHECK;
					end
				end
				ST_MUL_X:   state_q <= ST_MUL_Y;
				ST_MUL_Y:   state_q <= ST_SUM;
				ST_SUM:     state_q <= ST_ROOT_GO;
				ST_ROOT_GO: state_q <= ST_ROOT_WAIT;
				ST_ROOT_WAIT: begin
					if (root_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					dist_q  <= dist_add[tas_pkg::DIST_W] ? tas_pkg::DIST_MAX
						: dist_add[tas_pkg::DIST_W-1:0];
					time_q  <= time_add[tas_pkg::TIME_W] ? tas_pkg::TIME_MAX
						: time_add[tas_pkg::TIME_W-1:0];
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (time_q == '0) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					// hold until the output register is free, then restart the track
					if (out_free) begin
						m_valid_q   <= 1'b1;
						have_prev_q <= 1'b0;
						prev_x_q    <= '0;
						prev_y_q    <= '0;
						dist_q      <= '0;
						time_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dx_q   <= dx_abs[tas_pkg::DIFF_W-1:0];
			dy_q   <= dy_abs[tas_pkg::DIFF_W-1:0];
			tsec_q <= in_tsec;
		end
		if (state_q == ST_MUL_X) begin
			sq_q <= prod;
		end
		if (state_q == ST_MUL_Y) begin
			ssum_q <= {1'b0, sq_q};
			sq_q   <= prod;
		end
		if (state_q == ST_SUM) begin
			ssum_q <= ssum_q + {1'b0, sq_q};
		end
		if (state_q == ST_CHECK) begin
			avg_q  <= '0;
			zero_q <= 1'b1;
		end
		if ((state_q == ST_DIV_WAIT) && div_done) begin
			// saturate when the quotient spills past the Q32.16 range
			avg_q  <= (|quot[tas_pkg::DIVD_W-1:tas_pkg::DIST_W]) ? tas_pkg::DIST_MAX
				: quot[tas_pkg::DIST_W-1:0];
			zero_q <= 1'b0;
		end
		if ((state_q == ST_RESULT) && out_free) begin
			m_data_q <= tas_pkg::OUT_DATA_W'({time_q, dist_q, avg_q});
			m_user_q <= zero_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

FILE: hdl/tas_checker.sv
// ----------------------------------------------------------------------------
// Track average speed: port checker
// Watches the stream ports of the speed core over time.
// ----------------------------------------------------------------------------
`include "track_average_speed_core_assert.svh"

module tas_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [tas_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [tas_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              m_tuser
);

	logic in_word;
	logic in_first_bits;

	assign in_word       = s_tvalid && s_tready;
	assign in_first_bits = s_tlast || (s_tdata[0] == 1'b0) || (s_tdata[0] == 1'b1);

	// a stalled result word holds
	`TAS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// the block goes busy after it takes a word
	`TAS_ASSERT_NEXT(a_busy_after_word, in_word && in_first_bits, !s_tready)

	// zero time gives zero speed
	`TAS_ASSERT_NOW(a_zero_speed, m_tvalid && m_tuser, m_tdata[tas_pkg::DIST_W-1:0] == '0)

	// a clear zero-time flag means seconds were summed
	`TAS_ASSERT_NOW(a_time_nonzero, m_tvalid && !m_tuser,
		m_tdata[tas_pkg::OUT_DATA_W-1:2*tas_pkg::DIST_W] != '0)

	// a nonzero speed needs a nonzero path
	`TAS_ASSERT_NOW(a_speed_path, m_tvalid && (m_tdata[tas_pkg::DIST_W-1:0] != '0),
		m_tdata[2*tas_pkg::DIST_W-1:tas_pkg::DIST_W] != '0)

endmodule

bind track_average_speed_core tas_checker u_tas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
